### src/kstr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstr_pkg: shared types and constants for the key event block
// Holds the event kinds, register indexes, reset values and the frame
// descriptor that travels from the front end to the event sequencer.
// ----------------------------------------------------------------------------
package kstr_pkg;

  typedef enum logic [1:0] {
    EV_PRESS       = 2'd0,
    EV_RELEASE     = 2'd1,
    EV_RELEASE_ALL = 2'd2,
    EV_TAP         = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_MIN_GAP         = 2'd0,
    REG_HOLD_THRESHOLD  = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2
  } reg_index_t;

  localparam logic [15:0] MIN_GAP_RESET         = 16'd30;
  localparam logic [15:0] HOLD_THRESHOLD_RESET  = 16'd300;
  localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd30;

  localparam logic [7:0] MOD_CODE_BASE = 8'h80;

  // Event slots of one frame, in output order.
  localparam int EVENT_SLOTS    = 10;
  localparam int SLOT_MOD_FIRST = 0;
  localparam int SLOT_MOD_LAST  = 3;
  localparam int SLOT_REL_A     = 4;
  localparam int SLOT_PRESS_A   = 5;
  localparam int SLOT_REL_B     = 6;
  localparam int SLOT_PRESS_B   = 7;
  localparam int SLOT_REL_ALL   = 8;
  localparam int SLOT_TAP       = 9;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [EVENT_SLOTS-1:0] mask;       // which slots produce an event
    logic [3:0]             mod_press;  // per modifier slot: press, else release
    logic [7:0]             old_a;
    logic [7:0]             new_a;
    logic [7:0]             old_b;
    logic [7:0]             new_b;
  } frame_desc_t;

endpackage

### src/kstr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstr_front: frame filter and classifier
// Checks the minimum gap, tracks key state and typematic timing, and turns
// each accepted frame into a descriptor of the events it causes.
// ----------------------------------------------------------------------------
module kstr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   accept,
  input  logic [31:0]            now_ms,
  input  logic [7:0]             modifier_bits,
  input  logic [7:0]             key_a,
  input  logic [7:0]             key_b,
  output logic                   desc_push,
  output kstr_pkg::frame_desc_t  desc
);

  logic [15:0] min_gap_ms;
  logic [15:0] hold_delay_ms;
  logic [15:0] repeat_period_ms;

  // The held key always equals the previous slot a code, so prev_key_a
  // doubles as the typematic key.
  logic [7:0]  prev_modifiers;
  logic [7:0]  prev_key_a;
  logic [7:0]  prev_key_b;
  logic [31:0] last_accept_ms;
  logic [31:0] hold_begin_ms;
  logic [31:0] last_tap_ms;
  logic        repeating;

  logic [31:0] gap_delta;
  logic [31:0] hold_delta;
  logic [31:0] tap_delta;
  logic        gap_ok;
  logic        frame_ok;
  logic        tap_fire;
  logic        all_zero;
  logic        any_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms       <= kstr_pkg::MIN_GAP_RESET;
      hold_delay_ms    <= kstr_pkg::HOLD_THRESHOLD_RESET;
      repeat_period_ms <= kstr_pkg::REPEAT_INTERVAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kstr_pkg::REG_MIN_GAP:         min_gap_ms       <= cfg_data;
        kstr_pkg::REG_HOLD_THRESHOLD:  hold_delay_ms    <= cfg_data;
        kstr_pkg::REG_REPEAT_INTERVAL: repeat_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gap_delta  = now_ms - last_accept_ms;
    hold_delta = now_ms - hold_begin_ms;
    tap_delta  = now_ms - last_tap_ms;
    gap_ok     = gap_delta >= {16'd0, min_gap_ms};
    frame_ok   = accept && gap_ok;
    tap_fire   = (key_a != 8'd0) && (key_a == prev_key_a) &&
                 (hold_delta >= {16'd0, hold_delay_ms}) &&
                 (!repeating || (tap_delta >= {16'd0, repeat_period_ms}));
    all_zero   = (modifier_bits == 8'd0) && (key_a == 8'd0) && (key_b == 8'd0);
    any_old    = (prev_modifiers != 8'd0) || (prev_key_a != 8'd0) ||
                 (prev_key_b != 8'd0);

    desc.mask      = '0;
    desc.mod_press = modifier_bits[3:0];
    desc.old_a     = prev_key_a;
    desc.new_a     = key_a;
    desc.old_b     = prev_key_b;
    desc.new_b     = key_b;
    for (int i = 0; i < 4; i++) begin
      desc.mask[i] = modifier_bits[i] ^ prev_modifiers[i];
    end
    desc.mask[kstr_pkg::SLOT_REL_A]   = (key_a != prev_key_a) && (prev_key_a != 8'd0);
    desc.mask[kstr_pkg::SLOT_PRESS_A] = (key_a != prev_key_a) && (key_a != 8'd0);
    desc.mask[kstr_pkg::SLOT_REL_B]   = (key_b != prev_key_b) && (prev_key_b != 8'd0);
    desc.mask[kstr_pkg::SLOT_PRESS_B] = (key_b != prev_key_b) && (key_b != 8'd0);
    desc.mask[kstr_pkg::SLOT_REL_ALL] = all_zero && any_old;
    desc.mask[kstr_pkg::SLOT_TAP]     = tap_fire;

    desc_push = frame_ok && (desc.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_modifiers <= '0;
      prev_key_a     <= '0;
      prev_key_b     <= '0;
      last_accept_ms <= '0;
      hold_begin_ms  <= '0;
      last_tap_ms    <= '0;
      repeating      <= 1'b0;
    end else if (frame_ok) begin
      prev_modifiers <= modifier_bits;
      prev_key_a     <= key_a;
      prev_key_b     <= key_b;
      last_accept_ms <= now_ms;
      if (key_a == 8'd0) begin
        hold_begin_ms <= '0;
        last_tap_ms   <= '0;
        repeating     <= 1'b0;
      end else if (key_a != prev_key_a) begin
        hold_begin_ms <= now_ms;
        last_tap_ms   <= '0;
        repeating     <= 1'b0;
      end else if (tap_fire) begin
        last_tap_ms <= now_ms;
        repeating   <= 1'b1;
      end
    end
  end

endmodule

### src/kstr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstr_queue: descriptor queue between front end and sequencer
// A small circular buffer of frame descriptors with a fill count.
// ----------------------------------------------------------------------------
module kstr_queue #(
  parameter int Depth = kstr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  kstr_pkg::frame_desc_t  wr_data,
  output logic                   full,
  input  logic                   rd_en,
  output logic                   rd_valid,
  output kstr_pkg::frame_desc_t  rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  kstr_pkg::frame_desc_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/kstr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kstr_back: event sequencer
// Walks the event mask of one descriptor lowest slot first and emits one
// event per cycle into an output register while that register is free or popped.
// ----------------------------------------------------------------------------
module kstr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   desc_valid,
  input  kstr_pkg::frame_desc_t  desc_in,
  output logic                   desc_take,
  output logic                   out_valid,
  input  logic                   out_pop,
  output logic [1:0]             event_kind,
  output logic [7:0]             event_code,
  output logic                   last_event
);

  kstr_pkg::frame_desc_t        cur;
  logic [kstr_pkg::EVENT_SLOTS-1:0] cur_mask;
  logic [kstr_pkg::EVENT_SLOTS-1:0] rest_mask;
  logic [3:0]                   slot;
  logic                         emit;
  kstr_pkg::event_kind_t        kind_sel;
  logic [7:0]                   code_sel;

  always_comb begin
    slot = '0;
    for (int i = kstr_pkg::EVENT_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        slot = 4'(i);
      end
    end
    // Clearing the lowest set bit leaves the events still to come.
    rest_mask = cur_mask & (cur_mask - 1'b1);
    emit      = (cur_mask != '0) && (!out_valid || out_pop);
    desc_take = desc_valid && ((cur_mask == '0) || (emit && (rest_mask == '0)));

    kind_sel = kstr_pkg::EV_PRESS;
    code_sel = '0;
    unique case (slot) inside
      [4'(kstr_pkg::SLOT_MOD_FIRST):4'(kstr_pkg::SLOT_MOD_LAST)]: begin
        kind_sel = cur.mod_press[slot[1:0]] ? kstr_pkg::EV_PRESS : kstr_pkg::EV_RELEASE;
        code_sel = kstr_pkg::MOD_CODE_BASE + {6'd0, slot[1:0]};
      end
      4'(kstr_pkg::SLOT_REL_A): begin
        kind_sel = kstr_pkg::EV_RELEASE;
        code_sel = cur.old_a;
      end
      4'(kstr_pkg::SLOT_PRESS_A): begin
        kind_sel = kstr_pkg::EV_PRESS;
        code_sel = cur.new_a;
      end
      4'(kstr_pkg::SLOT_REL_B): begin
        kind_sel = kstr_pkg::EV_RELEASE;
        code_sel = cur.old_b;
      end
      4'(kstr_pkg::SLOT_PRESS_B): begin
        kind_sel = kstr_pkg::EV_PRESS;
        code_sel = cur.new_b;
      end
      4'(kstr_pkg::SLOT_REL_ALL): begin
        kind_sel = kstr_pkg::EV_RELEASE_ALL;
        code_sel = 8'd0;
      end
      4'(kstr_pkg::SLOT_TAP): begin
        kind_sel = kstr_pkg::EV_TAP;
        code_sel = cur.new_a;
      end
      default: begin
        kind_sel = kstr_pkg::EV_PRESS;
        code_sel = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (desc_take) begin
        cur_mask <= desc_in.mask;
      end else if (emit) begin
        cur_mask <= rest_mask;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take) begin
      cur <= desc_in;
    end
    if (emit) begin
      event_kind <= kind_sel;
      event_code <= code_sel;
      last_event <= (rest_mask == '0);
    end
  end

endmodule

### src/key_state_to_events_with_repeat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_to_events_with_repeat_unit: keyboard snapshots to key events
// Turns timestamped keyboard state snapshots into press, release,
// release-all and typematic tap events for the primary key.
// ----------------------------------------------------------------------------
// Path: the first event of a frame passes the queue, the sequencer's mask
// register and the output register. Throughput: one frame per cycle at the
// input while the descriptor queue has room; events leave one per cycle while
// the receiver pops, and a frame makes at most ten events.
// Reset (rst, synchronous): registers return to 30/300/30 ms, key state and
// timestamps clear to zero, the queue and the result register empty.
module key_state_to_events_with_repeat_unit #(
  parameter int QueueDepth = kstr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes, taken at once.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Frame input: a transfer happens when push is high and full is low.
  input  logic        push,
  output logic        full,
  input  logic [31:0] now_ms,
  input  logic [7:0]  modifier_bits,
  input  logic [7:0]  key_a,
  input  logic [7:0]  key_b,
  // Event output: a transfer happens when pop is high and empty is low.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind,
  output logic [7:0]  event_code,
  output logic        last_event
);

  // The front end decides everything about a frame in the cycle it arrives,
  // including its state updates, so a frame may follow in the next cycle.
  // Frames that are dropped by the gap check or cause no events never reach
  // the queue.
  logic                  accept;
  logic                  desc_push;
  kstr_pkg::frame_desc_t desc_front;
  kstr_pkg::frame_desc_t desc_back;
  logic                  desc_valid;
  logic                  desc_take;
  logic                  out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  kstr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .now_ms        (now_ms),
    .modifier_bits (modifier_bits),
    .key_a         (key_a),
    .key_b         (key_b),
    .desc_push     (desc_push),
    .desc          (desc_front)
  );

  // Full is taken from the queue even for frames that would push nothing;
  // the front end keeps its state and the sequencer drains independently.
  kstr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (desc_push),
    .wr_data  (desc_front),
    .full     (full),
    .rd_en    (desc_take),
    .rd_valid (desc_valid),
    .rd_data  (desc_back)
  );

  // The sequencer loads the next descriptor in the cycle it emits the last
  // event of the current one, so events of successive frames run gap-free.
  kstr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_in    (desc_back),
    .desc_take  (desc_take),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .event_kind (event_kind),
    .event_code (event_code),
    .last_event (last_event)
  );

endmodule

### dv/key_state_to_events_with_repeat_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_to_events_with_repeat_unit_tb: self-checking bench for key events
// Feeds timestamped keyboard snapshots into the unit and keeps a cycle-free
// prediction of the event stream. Every popped event is checked against the
// oldest predicted one. Directed cases run first, then phases of random
// traffic under several timing register settings, with bursty pushes and
// receiver stalls.
// ----------------------------------------------------------------------------
module key_state_to_events_with_repeat_unit_tb;

  // Index 3 has no register behind it, so writes there must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int RESET_CYCLES     = 7;
  // Frames that make no events never enter the queue, so once the last
  // expected event has left the unit is idle. The quiet cycles give any
  // stray event time to show up.
  localparam int QUIET_CYCLES     = 64;
  // The longest stretch without any transfer in a correct run is the quiet
  // wait above or a receiver stall, both far below this.
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PHASES    = 7;
  localparam int FRAMES_PER_PHASE = 37;

  // Receiver behavior, switched at random.
  typedef enum logic [1:0] {
    DRAIN_ALWAYS,
    DRAIN_COIN_FLIP,
    DRAIN_EVERY_FOURTH,
    DRAIN_LONG_STALLS
  } drain_mode_t;

  typedef struct packed {
    kstr_pkg::event_kind_t kind;
    logic [7:0]            code;
    logic                  last;
  } key_event_t;

  // DUT inputs start at known values.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_write     = 1'b0;
  logic [1:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;
  logic        push          = 1'b0;
  logic [31:0] now_ms        = '0;
  logic [7:0]  modifier_bits = '0;
  logic [7:0]  key_a         = '0;
  logic [7:0]  key_b         = '0;
  logic        pop           = 1'b0;

  logic        full;
  logic        empty;
  logic [1:0]  event_kind;
  logic [7:0]  event_code;
  logic        last_event;

  key_state_to_events_with_repeat_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .now_ms        (now_ms),
    .modifier_bits (modifier_bits),
    .key_a         (key_a),
    .key_b         (key_b),
    .empty         (empty),
    .pop           (pop),
    .event_kind    (event_kind),
    .event_code    (event_code),
    .last_event    (last_event)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Event predictor: its own copy of the timing registers and key state.
  // --------------------------------------------------------------------------
  logic [15:0] gap_cfg;
  logic [15:0] threshold_cfg;
  logic [15:0] interval_cfg;

  logic [7:0]  held_mods;
  logic [7:0]  held_a;
  logic [7:0]  held_b;
  logic [31:0] accepted_at;
  logic [7:0]  repeat_key;
  logic [31:0] hold_start;
  logic [31:0] tap_at;
  logic        tapping;

  // Events that the unit still owes us, oldest first.
  key_event_t pending_events[$];
  // Scratch list for the events of the frame being predicted.
  key_event_t frame_events[kstr_pkg::EVENT_SLOTS];
  int         frame_count;

  int error_count = 0;
  int quiet_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void add_event(input kstr_pkg::event_kind_t kind,
                                    input logic [7:0] code);
    key_event_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.last = 1'b0;
    frame_events[frame_count] = ev;
    frame_count++;
  endfunction

  task automatic predict_frame(input logic [31:0] t, input logic [7:0] mods,
                               input logic [7:0] ka, input logic [7:0] kb);
    logic [7:0]  old_mods;
    logic [7:0]  old_a;
    logic [7:0]  old_b;
    logic [31:0] since_accept;
    key_event_t  ev;
    old_mods     = held_mods;
    old_a        = held_a;
    old_b        = held_b;
    since_accept = t - accepted_at;
    frame_count  = 0;

    // A frame inside the minimum gap is dropped without touching any state.
    if (since_accept < {16'h0, gap_cfg}) return;

    // Only ctrl, shift, alt and gui make events; the upper bits are kept.
    for (int i = 0; i < 4; i++) begin
      if (mods[i] && !old_mods[i])
        add_event(kstr_pkg::EV_PRESS, kstr_pkg::MOD_CODE_BASE | 8'(i));
      else if (!mods[i] && old_mods[i])
        add_event(kstr_pkg::EV_RELEASE, kstr_pkg::MOD_CODE_BASE | 8'(i));
    end
    held_mods = mods;

    if (ka != held_a) begin
      if (held_a != 8'h00) add_event(kstr_pkg::EV_RELEASE, held_a);
      if (ka != 8'h00) add_event(kstr_pkg::EV_PRESS, ka);
      held_a = ka;
    end
    if (kb != held_b) begin
      if (held_b != 8'h00) add_event(kstr_pkg::EV_RELEASE, held_b);
      if (kb != 8'h00) add_event(kstr_pkg::EV_PRESS, kb);
      held_b = kb;
    end

    // Release-all only when the frame is blank and something was held before.
    if (mods == 8'h00 && ka == 8'h00 && kb == 8'h00 &&
        (old_mods != 8'h00 || old_a != 8'h00 || old_b != 8'h00))
      add_event(kstr_pkg::EV_RELEASE_ALL, 8'h00);

    // Typematic repeat follows the primary key only.
    if (ka == 8'h00) begin
      repeat_key = 8'h00;
      hold_start = '0;
      tap_at     = '0;
      tapping    = 1'b0;
    end else if (ka != repeat_key) begin
      repeat_key = ka;
      hold_start = t;
      tap_at     = '0;
      tapping    = 1'b0;
    end else if (t - hold_start >= {16'h0, threshold_cfg}) begin
      if (!tapping || (t - tap_at >= {16'h0, interval_cfg})) begin
        add_event(kstr_pkg::EV_TAP, repeat_key);
        tap_at  = t;
        tapping = 1'b1;
      end
    end

    accepted_at = t;

    for (int i = 0; i < frame_count; i++) begin
      ev      = frame_events[i];
      ev.last = (i == frame_count - 1);
      pending_events.push_back(ev);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sees every transfer at the rising edge. Prediction comes before
  // the result check so both sides are handled in one fixed order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    key_event_t head;
    if (rst) begin
      gap_cfg       = kstr_pkg::MIN_GAP_RESET;
      threshold_cfg = kstr_pkg::HOLD_THRESHOLD_RESET;
      interval_cfg  = kstr_pkg::REPEAT_INTERVAL_RESET;
      held_mods     = '0;
      held_a        = '0;
      held_b        = '0;
      accepted_at   = '0;
      repeat_key    = '0;
      hold_start    = '0;
      tap_at        = '0;
      tapping       = 1'b0;
      pending_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          kstr_pkg::REG_MIN_GAP:         gap_cfg       = cfg_data;
          kstr_pkg::REG_HOLD_THRESHOLD:  threshold_cfg = cfg_data;
          kstr_pkg::REG_REPEAT_INTERVAL: interval_cfg  = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) predict_frame(now_ms, modifier_bits, key_a, key_b);
      if (pop && !empty) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d code %02h last %0b",
                                    event_kind, event_code, last_event));
        end else begin
          head = pending_events.pop_front();
          if (event_kind !== head.kind)
            report_mismatch($sformatf("event_kind %0d, wanted %0d (code %02h)",
                                      event_kind, head.kind, head.code));
          if (event_code !== head.code)
            report_mismatch($sformatf("event_code %02h, wanted %02h",
                                      event_code, head.code));
          if (last_event !== head.last)
            report_mismatch($sformatf("last_event %0b, wanted %0b (code %02h)",
                                      last_event, head.last, head.code));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer or register write restarts the count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("[key_state_to_events_with_repeat_unit] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pop changes at the falling edge following a pattern of its own,
  // which covers steady draining, coin flips, a fixed one-in-four rhythm and
  // long stalls.
  // --------------------------------------------------------------------------
  drain_mode_t drain_mode = DRAIN_ALWAYS;
  int          mode_left  = 0;
  int          stall_left = 0;
  int          drain_tick = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    drain_tick++;
    case (drain_mode)
      DRAIN_ALWAYS:       pop <= 1'b1;
      DRAIN_COIN_FLIP:    pop <= 1'($urandom_range(0, 1));
      DRAIN_EVERY_FOURTH: pop <= (drain_tick % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(5, 15);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender side. Inputs change only at the falling edge. push stays high
  // across back-to-back frames and is lowered only when a gap begins.
  // --------------------------------------------------------------------------
  task automatic send_frame(input logic [31:0] t, input logic [7:0] mods,
                            input logic [7:0] ka, input logic [7:0] kb);
    @(negedge clk);
    push          <= 1'b1;
    now_ms        <= t;
    modifier_bits <= mods;
    key_a         <= ka;
    key_b         <= kb;
    // The transfer happens at the first rising edge that sees full low.
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender until every predicted event has been popped.
  task automatic drain_events;
    pause_sender(1);
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  // Registers may only change while the unit is idle. The quiet cycles
  // afterwards catch any stray event.
  task automatic wait_idle;
    drain_events();
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_timing(input logic [15:0] gap, input logic [15:0] threshold,
                                input logic [15:0] interval);
    write_reg(kstr_pkg::REG_MIN_GAP, gap);
    write_reg(kstr_pkg::REG_HOLD_THRESHOLD, threshold);
    write_reg(kstr_pkg::REG_REPEAT_INTERVAL, interval);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests. They run back to back from reset and each one builds on
  // the key state left by the one before.
  // --------------------------------------------------------------------------

  // Right after reset the last accepted time is zero, so frames stamped below
  // the default 30 ms gap are dropped, even a frame with every bit set.
  task automatic test_reset_window;
    send_frame(32'd0,  8'hFF, 8'hFF, 8'hFF);
    send_frame(32'd29, 8'hFF, 8'hFF, 8'hFF);
    // First accepted frame: four modifier presses plus both key slots.
    send_frame(32'd30, 8'h0F, 8'h04, 8'h05);
  endtask

  // Modifier edges, slot swaps, the upper modifier bits and release-all.
  task automatic test_modifiers_and_slots;
    // Low modifiers drop while the upper ones rise; slot a swaps codes and
    // slot b goes empty.
    send_frame(32'd60,  8'hF0, 8'hFF, 8'h00);
    // Inside the gap, so this one must vanish without a trace.
    send_frame(32'd70,  8'h01, 8'h11, 8'h22);
    // Upper modifier bits still count as held, so no release-all yet.
    send_frame(32'd100, 8'hF0, 8'h00, 8'h00);
    // Only the upper bits clear: no edge events, just the release-all.
    send_frame(32'd130, 8'h00, 8'h00, 8'h00);
    // Already blank, so the blank frame makes nothing at all.
    send_frame(32'd160, 8'h00, 8'h00, 8'h00);
    // Release-all following a lone secondary key.
    send_frame(32'd190, 8'h00, 8'h00, 8'h80);
    send_frame(32'd220, 8'h00, 8'h00, 8'h00);
  endtask

  // Hold threshold, repeat interval, and a restart when the key changes.
  task automatic test_typematic;
    send_frame(32'd300,  8'h00, 8'h1E, 8'h00);
    send_frame(32'd400,  8'h00, 8'h1E, 8'h00);
    // Exactly the threshold after the hold began: the first tap.
    send_frame(32'd600,  8'h00, 8'h1E, 8'h00);
    send_frame(32'd620,  8'h00, 8'h1E, 8'h00);
    send_frame(32'd630,  8'h00, 8'h1E, 8'h00);
    send_frame(32'd700,  8'h00, 8'h1E, 8'h00);
    // A new primary key restarts the hold and taps nothing.
    send_frame(32'd730,  8'h00, 8'h2C, 8'h00);
    // Many events from one frame: modifiers, slot b and the tap together.
    send_frame(32'd1030, 8'h0F, 8'h2C, 8'h33);
  endtask

  // Gap and hold times measured across the 32-bit wrap of the clock.
  task automatic test_time_wrap;
    send_frame(32'hFFFF_FFE0, 8'h0F, 8'h1E, 8'h33);
    send_frame(32'h0000_0002, 8'h0F, 8'h1E, 8'h33);
    send_frame(32'h0000_0010, 8'h0F, 8'h1E, 8'h33);
    send_frame(32'h0000_0120, 8'h0F, 8'h1E, 8'h33);
  endtask

  // Zero and full-scale registers, plus a write to the unused index.
  task automatic test_register_extremes;
    logic [31:0] t;
    t = 32'h1000_0000;
    wait_idle();
    program_timing(16'h0000, 16'h0000, 16'h0000);
    // Zero gap accepts frames with the same stamp; zero threshold taps on
    // the second frame of a hold, and zero interval on every one after.
    send_frame(t, 8'h0F, 8'h55, 8'h33);
    send_frame(t, 8'h0F, 8'h55, 8'h33);
    send_frame(t, 8'h0F, 8'h55, 8'h33);
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(t + 32'd65534, 8'h0F, 8'h55, 8'h33);
    send_frame(t + 32'd65535, 8'h0F, 8'h55, 8'h33);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly plausible typing with held keys, plus blank
  // frames and arbitrary codes and timestamps.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_key;
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h04;
      2:       return 8'h1E;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Time steps are drawn around the live register values so that gap,
  // threshold and interval decisions all land on both sides.
  function automatic logic [31:0] next_step;
    int gap;
    int threshold;
    int interval;
    gap       = gap_cfg;
    threshold = threshold_cfg;
    interval  = interval_cfg;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, gap);
      3, 4, 5: return gap + $urandom_range(0, interval + 16);
      6, 7, 8: return $urandom_range(0, threshold + threshold / 2 + 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_traffic;
    logic [31:0] t;
    logic [7:0]  mods;
    logic [7:0]  ka;
    logic [7:0]  kb;
    int          burst_left;
    t          = $urandom;
    mods       = '0;
    ka         = '0;
    kb         = '0;
    burst_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: program_timing(kstr_pkg::MIN_GAP_RESET, kstr_pkg::HOLD_THRESHOLD_RESET,
                          kstr_pkg::REPEAT_INTERVAL_RESET);
        1: program_timing(16'h0000, 16'h0000, 16'h0000);
        2: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_timing(16'($urandom_range(1, 20)), 16'($urandom_range(20, 200)),
                          16'($urandom_range(1, 40)));
        4: program_timing(16'($urandom_range(0, 50)), 16'($urandom_range(0, 100)),
                          16'hFFFF);
        default: program_timing(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (phase == 5) write_reg(REG_UNUSED, 16'($urandom));

      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        // Bursts of back-to-back frames separated by random gaps.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
        burst_left--;
        // Now and then the sender holds off until the unit has caught up.
        if ($urandom_range(0, 39) == 0) drain_events();

        t = t + next_step();
        if ($urandom_range(0, 19) < 3) begin
          mods = '0;
          ka   = '0;
          kb   = '0;
        end else begin
          if ($urandom_range(0, 3) == 0)
            mods = $urandom_range(0, 1) ? 8'($urandom) : {4'h0, 4'($urandom)};
          if ($urandom_range(0, 4) == 0) ka = pick_key();
          if ($urandom_range(0, 2) == 0) kb = pick_key();
        end
        send_frame(t, mods, ka, kb);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_modifiers_and_slots();
    test_typematic();
    test_time_wrap();
    test_register_extremes();
    test_random_traffic();

    // Let the last events out, then watch a while for stray ones.
    wait_idle();
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

    if (error_count == 0) begin
      $display("[key_state_to_events_with_repeat_unit] OK");
    end else begin
      $display("[key_state_to_events_with_repeat_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/kstr_pkg.sv
src/kstr_front.sv
src/kstr_queue.sv
src/kstr_back.sv
src/key_state_to_events_with_repeat_unit.sv
dv/key_state_to_events_with_repeat_unit_tb.sv
